// ----- design/kwm_pkg.sv -----
// Shared types, request and status codes for the k-way sorted merge core.
package kwm_pkg;

	localparam logic [1:0] REQ_APPEND  = 2'd0;
	localparam logic [1:0] REQ_POP     = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;
	localparam logic [1:0] REQ_POP_ALT = 2'd3;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [2:0] STS_APPENDED = 3'd0;
	localparam logic [2:0] STS_DROPPED  = 3'd1;
	localparam logic [2:0] STS_POPPED   = 3'd2;
	localparam logic [2:0] STS_EMPTY    = 3'd3;
	localparam logic [2:0] STS_CLEARED  = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [2:0]         list_index;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] merged_value;
		logic [2:0]         status;
		logic               last;
	} rsp_t;

	// Map a request code to an operation; the spare code acts as a pop.
	function automatic logic [1:0] kwm_decode(input logic [1:0] req_type);
		logic [1:0] op;
		unique case (req_type) inside
			REQ_APPEND:           op = OP_APPEND;
			REQ_POP, REQ_POP_ALT: op = OP_POP;
			REQ_CLEAR:            op = OP_CLEAR;
			default:              op = OP_POP;
		endcase
		return op;
	endfunction

endpackage

// ----- design/kwm_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int AW    = 9
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Hold the last read word until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- design/kwm_head_min.sv -----
// Argmin tree over the cached list heads; ties go to the lower list.
module kwm_head_min #(
	parameter int NUM_LISTS = 8
) (
	input  logic signed [31:0]                   head [NUM_LISTS],
	input  logic [NUM_LISTS-1:0]                 head_vld,
	output logic                                 found,
	output logic [$clog2(NUM_LISTS)-1:0]         idx,
	output logic signed [31:0]                   value
);
	import kwm_pkg::*;

	localparam int LW    = $clog2(NUM_LISTS);
	localparam int SLOTS = 1 << LW;
	localparam int NODES = 2 * SLOTS - 1;

	logic               nv   [NODES];
	logic signed [31:0] nval [NODES];
	logic [LW-1:0]      nidx [NODES];

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			if (k < NUM_LISTS) begin
				nv[SLOTS-1+k]   = head_vld[k];
				nval[SLOTS-1+k] = head[k];
			end else begin
				nv[SLOTS-1+k]   = 1'b0;
				nval[SLOTS-1+k] = '0;
			end
			nidx[SLOTS-1+k] = LW'(k);
		end
		// Combine pairs level by level; the left child wins on a tie.
		for (int i = SLOTS - 2; i >= 0; i--) begin
			if (nv[2*i+1] && (!nv[2*i+2] || (nval[2*i+1] <= nval[2*i+2]))) begin
				nv[i]   = 1'b1;
				nval[i] = nval[2*i+1];
				nidx[i] = nidx[2*i+1];
			end else begin
				nv[i]   = nv[2*i+2];
				nval[i] = nval[2*i+2];
				nidx[i] = nidx[2*i+2];
			end
		end
	end

	assign found = nv[0];
	assign idx   = nidx[0];
	assign value = nval[0];
endmodule

// ----- design/k_way_sorted_merge_core.sv -----
// Top level of the k-way sorted merge core: control, head cache and memories.
//
//  channel | valid     | ready     | word            | accepted when
//  --------+-----------+-----------+-----------------+----------------------
//  request | req_valid | req_ready | req (req_t)     | req_valid & req_ready
//  result  | rsp_valid | rsp_ready | rsp (rsp_t)     | rsp_valid & rsp_ready
//
//  Append and clear go through accept (counter RAM read), then execute.
//  A pop that leaves entries in its list adds a refill step: the cached
//  head is reloaded from the registered read of the value RAM.
//  Reset and clear drop every counter valid bit and head valid bit at once;
//  no clearing pass is needed.
//  A result waiting in the output register stalls only the execute step;
//  a new request is still taken while that result waits.
module k_way_sorted_merge_core #(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  kwm_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output kwm_pkg::rsp_t  rsp
);
	import kwm_pkg::*;

	localparam int LW = $clog2(NUM_LISTS);
	localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_REFILL = 2'd2;

	logic [1:0] state_q, state_d;

	// Request captured at accept.
	logic [1:0]         op_q;
	logic               in_range_q;
	logic [LW-1:0]      lst_q;
	logic signed [31:0] val_q;
	logic               found_q;
	logic signed [31:0] min_val_q;

	// Cached heads: one per list, valid while the list has unread entries.
	logic signed [31:0]   head_q [NUM_LISTS];
	logic [NUM_LISTS-1:0] head_vld_q;
	// Counter RAM entries read as zero until written after reset or clear.
	logic [NUM_LISTS-1:0] cnt_vld_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic               min_found;
	logic [LW-1:0]      min_idx;
	logic signed [31:0] min_val;

	logic               accept;
	logic [1:0]         op_in;
	logic [LW-1:0]      lst_in;
	logic [LW-1:0]      cnt_raddr;
	logic [2*CW-1:0]    cnt_rdata;
	logic               cnt_we;
	logic [2*CW-1:0]    cnt_wdata;
	logic               store_we;
	logic               store_re;
	logic [LW+PW-1:0]   store_waddr;
	logic [LW+PW-1:0]   store_raddr;
	logic [31:0]        store_rdata;

	logic [CW-1:0] fill, rpos, rpos_nxt;
	logic          full, refill;
	logic          exec_done;
	logic          more;
	rsp_t          rsp_d;
	logic          head_load, head_drop;

	kwm_head_min #(.NUM_LISTS(NUM_LISTS)) u_min (
		.head     (head_q),
		.head_vld (head_vld_q),
		.found    (min_found),
		.idx      (min_idx),
		.value    (min_val)
	);

	kwm_ram #(.WIDTH(2 * CW), .AW(LW)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (lst_q),
		.wdata (cnt_wdata),
		.re    (accept),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	kwm_ram #(.WIDTH(32), .AW(LW + PW)) u_store_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (val_q),
		.re    (store_re),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign op_in     = kwm_decode(req.req_type);
	assign lst_in    = LW'(req.list_index);
	// A pop works on the list whose head is the smallest right now.
	assign cnt_raddr = (op_in == OP_POP) ? min_idx : lst_in;

	// Counters of the selected list; an entry not written since clear is zero.
	assign fill     = cnt_vld_q[lst_q] ? cnt_rdata[2*CW-1:CW] : '0;
	assign rpos     = cnt_vld_q[lst_q] ? cnt_rdata[CW-1:0] : '0;
	assign rpos_nxt = rpos + CW'(1);
	assign full     = (fill == CW'(LIST_DEPTH));
	assign refill   = (rpos_nxt < fill);

	// Finish the step only when the output register is free.
	assign exec_done = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);

	assign store_waddr = {lst_q, fill[PW-1:0]};
	assign store_raddr = {lst_q, rpos_nxt[PW-1:0]};

	always_comb begin
		more = (|(head_vld_q & ~(NUM_LISTS'(1) << lst_q))) || refill;
	end

	always_comb begin
		state_d   = state_q;
		cnt_we    = 1'b0;
		cnt_wdata = {fill, rpos};
		store_we  = 1'b0;
		store_re  = 1'b0;
		head_load = 1'b0;
		head_drop = 1'b0;
		rsp_d     = '{merged_value: '0, status: STS_CLEARED, last: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_APPEND: begin
						if (in_range_q && !full) begin
							rsp_d.status = STS_APPENDED;
							cnt_wdata    = {fill + CW'(1), rpos};
							cnt_we       = exec_done;
							store_we     = exec_done;
							head_load    = exec_done && !head_vld_q[lst_q];
						end else begin
							rsp_d.status = STS_DROPPED;
						end
					end
					OP_POP: begin
						if (found_q) begin
							rsp_d.status       = STS_POPPED;
							rsp_d.merged_value = min_val_q;
							rsp_d.last         = !more;
							cnt_wdata          = {fill, rpos_nxt};
							cnt_we             = exec_done;
							store_re           = exec_done && refill;
							head_drop          = exec_done && !refill;
						end else begin
							rsp_d.status = STS_EMPTY;
						end
					end
					default: begin
						rsp_d.status = STS_CLEARED;
					end
				endcase
				if (exec_done) begin
					state_d = store_re ? S_REFILL : S_IDLE;
				end
			end
			S_REFILL: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_vld_q  <= '0;
			cnt_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (exec_done && (op_q == OP_CLEAR)) begin
				head_vld_q <= '0;
				cnt_vld_q  <= '0;
			end else begin
				if (cnt_we) begin
					cnt_vld_q[lst_q] <= 1'b1;
				end
				if (head_load) begin
					head_vld_q[lst_q] <= 1'b1;
				end
				if (head_drop) begin
					head_vld_q[lst_q] <= 1'b0;
				end
			end
		end
	end

	// Payload registers: request capture, head cache and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_in;
			in_range_q <= (32'(req.list_index) < NUM_LISTS);
			lst_q      <= cnt_raddr;
			val_q      <= req.value;
			found_q    <= min_found;
			min_val_q  <= min_val;
		end
		if (exec_done) begin
			rsp_q <= rsp_d;
		end
		if (head_load) begin
			head_q[lst_q] <= val_q;
		end
		// Advance the head of the popped list to its next entry.
		if (state_q == S_REFILL) begin
			head_q[lst_q] <= store_rdata;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
